@@ src/char_lcd_shift_register_sequencer_defines.svh @@
// assertion macros shared by the lcd shift-register sequencer
`ifndef CHAR_LCD_SHIFT_REGISTER_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_SHIFT_REGISTER_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
`define CLSRS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clsrs assertion failed");
`define CLSRS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clsrs assertion failed");
`else
`define CLSRS_ASSERT_IMP(label, ante, cons)
`define CLSRS_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ src/clsrs_pkg.sv @@
// types and constants of the lcd shift-register sequencer
`timescale 1ns / 1ps
package clsrs_pkg;

  // request kinds
  localparam logic [3:0] MODE_CHAR   = 4'd0;
  localparam logic [3:0] MODE_CMD    = 4'd1;
  localparam logic [3:0] MODE_SETPOS = 4'd2;
  localparam logic [3:0] MODE_HOME   = 4'd3;
  localparam logic [3:0] MODE_BKLT   = 4'd4;
  localparam logic [3:0] MODE_RS     = 4'd5;
  localparam logic [3:0] MODE_NIB    = 4'd6;
  localparam logic [3:0] MODE_BYTE   = 4'd7;
  localparam logic [3:0] MODE_RESET  = 4'd8;

  // shift-register control bits
  localparam logic [7:0] BIT_BKLT  = 8'h08;
  localparam logic [7:0] BIT_EN    = 8'h04;
  localparam logic [7:0] BIT_RS    = 8'h01;
  localparam logic [7:0] CMD_DDRAM = 8'h80;
  localparam logic [7:0] CMD_LINE2 = 8'hC0;

  // sequence kinds handed from front to back
  localparam logic [2:0] SEQ_BYTE = 3'd0;
  localparam logic [2:0] SEQ_CMD  = 3'd1;
  localparam logic [2:0] SEQ_NIB  = 3'd2;
  localparam logic [2:0] SEQ_SET  = 3'd3;
  localparam logic [2:0] SEQ_CLR  = 3'd4;
  localparam logic [2:0] SEQ_ZERO = 3'd5;

  // per-byte operations of the back end
  localparam logic [2:0] UOP_LOAD   = 3'd0;
  localparam logic [2:0] UOP_STROBE = 3'd1;
  localparam logic [2:0] UOP_HOLD   = 3'd2;
  localparam logic [2:0] UOP_SET    = 3'd3;
  localparam logic [2:0] UOP_CLR    = 3'd4;
  localparam logic [2:0] UOP_ZERO   = 3'd5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] shift_byte;
    logic       last_of_run;
    logic [7:0] cursor_column;
  } out_word_t;

  typedef struct packed {
    logic [2:0] seq;
    logic [7:0] data;
    logic [7:0] mask;
    logic [7:0] column;
  } desc_t;

endpackage

@@ src/clsrs_front.sv @@
// front end: takes requests, tracks the column and builds sequence descriptors
`timescale 1ns / 1ps
module clsrs_front import clsrs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  in_word_t req_word,
  input  logic     q_full,
  output logic     q_push,
  output desc_t    q_desc
);

  logic [7:0] column, column_next;
  logic       known;
  logic       accept;

  assign req_ready = !q_full;
  assign accept    = req_valid && req_ready;

  always_comb begin
    known        = 1'b1;
    column_next  = column;
    q_desc.seq   = SEQ_BYTE;
    q_desc.data  = req_word.value;
    q_desc.mask  = BIT_RS;
    case (req_word.mode)
      MODE_CHAR: begin
        column_next = column + 8'd1;
      end
      MODE_CMD: begin
        q_desc.seq = SEQ_CMD;
      end
      MODE_SETPOS: begin
        q_desc.seq  = SEQ_CMD;
        q_desc.data = CMD_DDRAM | req_word.value;
        column_next = req_word.value;
      end
      MODE_HOME: begin
        q_desc.seq  = SEQ_CMD;
        q_desc.data = req_word.value[0] ? CMD_LINE2 : CMD_DDRAM;
        column_next = 8'd0;
      end
      MODE_BKLT: begin
        q_desc.seq  = req_word.value[0] ? SEQ_SET : SEQ_CLR;
        q_desc.mask = BIT_BKLT;
      end
      MODE_RS: begin
        q_desc.seq = req_word.value[0] ? SEQ_SET : SEQ_CLR;
      end
      MODE_NIB: begin
        q_desc.seq = SEQ_NIB;
      end
      MODE_BYTE: begin
        q_desc.seq = SEQ_BYTE;
      end
      MODE_RESET: begin
        q_desc.seq  = SEQ_ZERO;
        column_next = 8'd0;
      end
      default: begin
        // undefined modes are swallowed without effect
        known = 1'b0;
      end
    endcase
    q_desc.column = column_next;
  end

  assign q_push = accept && known;

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= 8'd0;
    end else if (accept) begin
      column <= column_next;
    end
  end

endmodule

@@ src/clsrs_queue.sv @@
// two-entry descriptor queue between front and back
`timescale 1ns / 1ps
`include "char_lcd_shift_register_sequencer_defines.svh"
module clsrs_queue import clsrs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output desc_t head_desc
);

  desc_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_desc  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  `CLSRS_ASSERT_IMP(a_count_bound, 1'b1, count <= QCNT_W'(QUEUE_DEPTH))
  `CLSRS_ASSERT_IMP(a_no_push_full, push, !full)
  `CLSRS_ASSERT_IMP(a_no_pop_empty, pop, head_valid)

endmodule

@@ src/clsrs_back.sv @@
// back end: walks a descriptor byte by byte and keeps the shift image
`timescale 1ns / 1ps
`include "char_lcd_shift_register_sequencer_defines.svh"
module clsrs_back import clsrs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  desc_t     q_desc,
  output logic      q_pop,
  output logic      res_valid,
  input  logic      res_ready,
  output out_word_t res_word
);

  logic [7:0] image, image_next, byte_out;
  logic [2:0] step, bstep, uop;
  logic       use_byte, last, advance;
  logic [3:0] nib;

  always_comb begin
    use_byte = 1'b0;
    bstep    = step;
    last     = 1'b0;
    uop      = UOP_HOLD;
    case (q_desc.seq)
      SEQ_BYTE: begin
        use_byte = 1'b1;
        last     = (step == 3'd5);
      end
      SEQ_CMD: begin
        // rs low, the byte, then rs high again
        if (step == 3'd0) begin
          uop = UOP_CLR;
        end else if (step == 3'd7) begin
          uop  = UOP_SET;
          last = 1'b1;
        end else begin
          use_byte = 1'b1;
          bstep    = step - 3'd1;
        end
      end
      SEQ_NIB: begin
        use_byte = 1'b1;
        bstep    = step + 3'd3;
        last     = (step == 3'd2);
      end
      SEQ_SET: begin
        uop  = UOP_SET;
        last = 1'b1;
      end
      SEQ_CLR: begin
        uop  = UOP_CLR;
        last = 1'b1;
      end
      SEQ_ZERO: begin
        uop  = UOP_ZERO;
        last = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase
    if (use_byte) begin
      case (bstep)
        3'd0, 3'd3: uop = UOP_LOAD;
        3'd1, 3'd4: uop = UOP_STROBE;
        default:    uop = UOP_HOLD;
      endcase
    end
  end

  // high nibble on the first three bytes of a word, low nibble after
  assign nib = (bstep < 3'd3) ? q_desc.data[7:4] : q_desc.data[3:0];

  always_comb begin
    image_next = image;
    byte_out   = image;
    case (uop)
      UOP_LOAD: begin
        image_next = {nib, image[3:0]};
        byte_out   = image_next;
      end
      UOP_STROBE: begin
        byte_out = image | BIT_EN;
      end
      UOP_SET: begin
        image_next = image | q_desc.mask;
        byte_out   = image_next;
      end
      UOP_CLR: begin
        image_next = image & ~q_desc.mask;
        byte_out   = image_next;
      end
      UOP_ZERO: begin
        image_next = 8'd0;
        byte_out   = 8'd0;
      end
      default: begin
        byte_out = image;
      end
    endcase
  end

  assign advance = q_valid && (!res_valid || res_ready);
  assign q_pop   = advance && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      image     <= 8'd0;
      step      <= 3'd0;
      res_valid <= 1'b0;
    end else if (advance) begin
      image     <= image_next;
      step      <= last ? 3'd0 : step + 3'd1;
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_word.shift_byte    <= byte_out;
      res_word.last_of_run   <= last;
      res_word.cursor_column <= q_desc.column;
    end
  end

  // a run under way keeps its descriptor at the queue head
  `CLSRS_ASSERT_IMP(a_run_has_head, step != 3'd0, q_valid)
  `CLSRS_ASSERT_NXT(a_pop_restarts, q_pop, step == 3'd0)

endmodule

@@ src/char_lcd_shift_register_sequencer.sv @@
// top level of the character-lcd shift-register sequencer
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid/req_ready  | mode, value
//   res     | out       | res_valid/res_ready  | shift_byte, last_of_run, cursor_column
//
// one result word leaves per cycle while the queue has a descriptor and res is free;
// a request yields 1, 3, 6 or 8 bytes in the back end, one byte per step, by its sequence.
// the front takes a request per cycle while the two-entry queue has room.
// a first result comes from the output register once its descriptor heads the queue.
// reset is synchronous and clears shift image, column, queue and step counter.
// a stall on res holds the back end only; the front fills the queue meanwhile.
`timescale 1ns / 1ps
module char_lcd_shift_register_sequencer import clsrs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  in_word_t  req_word,
  output logic      res_valid,
  input  logic      res_ready,
  output out_word_t res_word
);

  logic  q_full, q_push, q_pop, q_valid;
  desc_t push_desc, head_desc;

  clsrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_word  (req_word),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (push_desc)
  );

  clsrs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_desc  (head_desc)
  );

  clsrs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_desc    (head_desc),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

endmodule
